[sv/aging_presence_table_green_time_top_defines.svh]
// Assertion macros used by the presence table control RTL.
`ifndef AGING_PRESENCE_TABLE_GREEN_TIME_TOP_DEFINES_SVH
`define AGING_PRESENCE_TABLE_GREEN_TIME_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset.
`define APTG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("presence table assertion failed");
// Check that a condition leads to a consequence in the next cycle.
`define APTG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("presence table sequencing assertion failed");
`else
`define APTG_ASSERT(lbl, prop)
`define APTG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/aptg_pkg.sv]
package aptg_pkg;

    // Table geometry
    localparam int ENTRIES  = 32;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int LIMIT_W  = 8;
    localparam int CMP_W    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Port field widths
    localparam int TIME_W       = 32;
    localparam int VKEY_W       = 32;
    localparam int COUNT_OUT_W  = 6;
    localparam int GREEN_W      = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    // Register reset values
    localparam logic [TIME_W-1:0]  EXPIRY_RST  = 32'd30000;
    localparam logic [LIMIT_W-1:0] FEW_RST     = 8'd5;
    localparam logic [LIMIT_W-1:0] MANY_RST    = 8'd15;
    localparam logic [GREEN_W-1:0] SHORT_RST   = 8'd5;
    localparam logic [GREEN_W-1:0] MEDIUM_RST  = 8'd10;
    localparam logic [GREEN_W-1:0] LONG_RST    = 8'd20;

    typedef enum logic
    {
        ACT_REPORT = 1'b0,
        ACT_QUERY  = 1'b1
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_EXPIRY = 3'd0,
        CFG_FEW    = 3'd1,
        CFG_MANY   = 3'd2,
        CFG_SHORT  = 3'd3,
        CFG_MEDIUM = 3'd4,
        CFG_LONG   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_RESULT
    } state_t;

    typedef struct packed
    {
        logic                valid;
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   seen;
    } entry_t;

    typedef struct packed
    {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } entry_wr_t;

    typedef struct packed
    {
        logic [TIME_W-1:0]  expiry;
        logic [LIMIT_W-1:0] few;
        logic [LIMIT_W-1:0] many;
        logic [GREEN_W-1:0] green_short;
        logic [GREEN_W-1:0] green_medium;
        logic [GREEN_W-1:0] green_long;
    } cfg_t;

endpackage

[sv/aptg_if.sv]
// Input channel: one report or query per transfer.
interface aptg_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] vehicle_key;
    logic [31:0] now_ms;

    modport source (output valid, action, vehicle_key, now_ms, input ready);
    modport sink   (input valid, action, vehicle_key, now_ms, output ready);
endinterface

// Output channel: one result per transfer.
interface aptg_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] active_count;
    logic [7:0] green_seconds;
    logic       insert_dropped;

    modport source (output valid, active_count, green_seconds, insert_dropped, input ready);
    modport sink   (input valid, active_count, green_seconds, insert_dropped, output ready);
endinterface

[sv/aptg_cell.sv]
module aptg_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift_en,
    input  aptg_pkg::entry_t shift_in,
    input  logic            load_en,
    input  aptg_pkg::entry_t load_data,
    output aptg_pkg::entry_t entry
);
    import aptg_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TIME_W-1:0]   seen_reg;
    logic [TIME_W-1:0]   seen_next;

    // Pick load over shift, otherwise hold
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        seen_next  = seen_reg;
        if (load_en)
        begin
            valid_next = load_data.valid;
            key_next   = load_data.key;
            seen_next  = load_data.seen;
        end
        else if (shift_en)
        begin
            valid_next = shift_in.valid;
            key_next   = shift_in.key;
            seen_next  = shift_in.seen;
        end
    end

    // Valid bit clears on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Key and time carry no reset
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        seen_reg <= seen_next;
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.seen  = seen_reg;

endmodule

[sv/aptg_ctrl.sv]
`include "aging_presence_table_green_time_top_defines.svh"

module aptg_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    aptg_in_if.sink              in_ch,
    aptg_out_if.source           out_ch,
    input  aptg_pkg::cfg_t       cfg,
    input  aptg_pkg::entry_t     head,
    output aptg_pkg::entry_t     ring_in,
    output logic                 shift_en,
    output aptg_pkg::entry_wr_t  wr
);
    import aptg_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [IDX_W-1:0]    step_reg;
    logic [IDX_W-1:0]    step_next;
    logic                action_reg;
    logic                action_next;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   now_next;
    logic                found_reg;
    logic                found_next;
    logic                free_found_reg;
    logic                free_found_next;
    logic [IDX_W-1:0]    free_idx_reg;
    logic [IDX_W-1:0]    free_idx_next;
    logic                dropped_reg;
    logic                dropped_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [COUNT_OUT_W-1:0]   out_count_reg;
    logic [COUNT_OUT_W-1:0]   out_count_next;
    logic [GREEN_W-1:0]       out_green_reg;
    logic [GREEN_W-1:0]       out_green_next;
    logic                     out_dropped_reg;
    logic                     out_dropped_next;

    logic                 in_xfer;
    logic                 last_step;
    logic                 head_match;
    logic                 head_expire;
    logic [TIME_W-1:0]    head_age;
    logic                 do_insert;
    logic                 out_free;
    logic [CMP_W-1:0]     count_cmp;
    logic [GREEN_W-1:0]   green_pick;

    assign in_xfer   = in_ch.valid && in_ch.ready;
    assign last_step = (step_reg == IDX_W'(ENTRIES - 1));
    assign out_free  = !out_valid_reg || out_ch.ready;

    // Compare the head cell against the current item
    assign head_age    = now_reg - head.seen;
    assign head_match  = (action_reg == ACT_REPORT) && head.valid && (head.key == key_reg);
    assign head_expire = (action_reg == ACT_QUERY) && head.valid && (head_age > cfg.expiry);
    assign do_insert   = (state_reg == S_FINISH) && (action_reg == ACT_REPORT)
                         && !found_reg && free_found_reg;

    // Pick green time from the count thresholds
    assign count_cmp = CMP_W'(count_reg);
    always_comb
    begin
        if (count_reg == '0)
        begin
            green_pick = '0;
        end
        else if (count_cmp < CMP_W'(cfg.few))
        begin
            green_pick = cfg.green_short;
        end
        else if (count_cmp < CMP_W'(cfg.many))
        begin
            green_pick = cfg.green_medium;
        end
        else
        begin
            green_pick = cfg.green_long;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_step)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Handshake, ring and write outputs
    always_comb
    begin
        in_ch.ready    = (state_reg == S_IDLE);
        shift_en       = (state_reg == S_SCAN);
        ring_in.valid  = head.valid && !head_expire;
        ring_in.key    = head.key;
        ring_in.seen   = head_match ? now_reg : head.seen;
        wr.en          = do_insert;
        wr.idx         = free_idx_reg;
        wr.data.valid  = 1'b1;
        wr.data.key    = key_reg;
        wr.data.seen   = now_reg;
    end

    // Item tracking and count
    always_comb
    begin
        step_next       = step_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        dropped_next    = dropped_reg;
        count_next      = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    step_next       = '0;
                    action_next     = in_ch.action;
                    key_next        = KEY_BITS'(in_ch.vehicle_key);
                    now_next        = in_ch.now_ms;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    dropped_next    = 1'b0;
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + 1'b1;
                if (head_match)
                begin
                    found_next = 1'b1;
                end
                if (!head.valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = step_reg;
                end
                if (head_expire)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                if (do_insert)
                begin
                    count_next = count_reg + 1'b1;
                end
                dropped_next = (action_reg == ACT_REPORT) && !found_reg && !free_found_reg;
            end
            S_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_count_next   = out_count_reg;
        out_green_next   = out_green_reg;
        out_dropped_next = out_dropped_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_RESULT) && out_free)
        begin
            out_valid_next   = 1'b1;
            out_count_next   = COUNT_OUT_W'(count_reg);
            out_green_next   = green_pick;
            out_dropped_next = dropped_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.active_count   = out_count_reg;
    assign out_ch.green_seconds  = out_green_reg;
    assign out_ch.insert_dropped = out_dropped_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        action_reg      <= action_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        found_reg       <= found_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        dropped_reg     <= dropped_next;
        out_count_reg   <= out_count_next;
        out_green_reg   <= out_green_next;
        out_dropped_reg <= out_dropped_next;
    end

    `APTG_ASSERT(a_count_range, count_reg <= CNT_W'(ENTRIES))
    `APTG_ASSERT_NEXT(a_accept_scan, in_xfer, state_reg == S_SCAN)
    `APTG_ASSERT_NEXT(a_scan_length, (state_reg == S_SCAN) && last_step, state_reg == S_FINISH)
    `APTG_ASSERT(a_drop_full, ((state_reg == S_FINISH) && (action_reg == ACT_REPORT) && !found_reg && !free_found_reg) |-> (count_reg == CNT_W'(ENTRIES)))

endmodule

[sv/aging_presence_table_green_time_top.sv]
// Presence table with aging and green-time selection. A report adds or refreshes a
// vehicle key; a query drops entries older than expiry_ms. Every item returns the
// active count with its green duration as a registered result: the table is a
// ring of 32 cells that rotates one entry per cycle past a single key/age compare
// unit, then the finish state writes an inserted key and the result state loads
// the result register once the output is free. A new item is taken as soon as
// the result is registered, even while that result waits downstream.
// Configuration goes through cfg_we/cfg_idx/cfg_data and must be written while idle.
module aging_presence_table_green_time_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    aptg_in_if.sink                              in_ch,
    aptg_out_if.source                           out_ch,
    input  logic                                 cfg_we,
    input  logic [aptg_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [aptg_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import aptg_pkg::*;

    cfg_t      cfg_reg;
    cfg_t      cfg_next;
    entry_t    cell_q [ENTRIES];
    entry_t    ring_in;
    logic      shift_en;
    entry_wr_t wr;

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_EXPIRY: cfg_next.expiry       = cfg_data;
                CFG_FEW:    cfg_next.few          = cfg_data[LIMIT_W-1:0];
                CFG_MANY:   cfg_next.many         = cfg_data[LIMIT_W-1:0];
                CFG_SHORT:  cfg_next.green_short  = cfg_data[GREEN_W-1:0];
                CFG_MEDIUM: cfg_next.green_medium = cfg_data[GREEN_W-1:0];
                CFG_LONG:   cfg_next.green_long   = cfg_data[GREEN_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expiry       <= EXPIRY_RST;
            cfg_reg.few          <= FEW_RST;
            cfg_reg.many         <= MANY_RST;
            cfg_reg.green_short  <= SHORT_RST;
            cfg_reg.green_medium <= MEDIUM_RST;
            cfg_reg.green_long   <= LONG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Ring of table cells; the last cell takes the updated head entry
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        entry_t shift_src;
        if (i == ENTRIES - 1)
        begin : g_tail
            assign shift_src = ring_in;
        end
        else
        begin : g_body
            assign shift_src = cell_q[i + 1];
        end

        aptg_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (shift_en),
            .shift_in  (shift_src),
            .load_en   (wr.en && (wr.idx == IDX_W'(i))),
            .load_data (wr.data),
            .entry     (cell_q[i])
        );
    end

    aptg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg      (cfg_reg),
        .head     (cell_q[0]),
        .ring_in  (ring_in),
        .shift_en (shift_en),
        .wr       (wr)
    );

endmodule
